// ===== src/http_request_header_parser_defines.svh =====
// Assertion macros shared by the parser RTL.
`ifndef HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

`define HRHP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HRHP_ASSERT_IMPLY(label, ante, cons, msg)

`define HRHP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/hrhp_pkg.sv =====
package hrhp_pkg;

  // Configuration register indexes (byte address 4 * index).
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LINE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_NAME  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_HDRS  = 2'd3;

  localparam logic [11:0] MAX_LINE_RST  = 12'd1024;
  localparam logic [7:0]  MAX_NAME_RST  = 8'd32;
  localparam logic [11:0] MAX_VALUE_RST = 12'd1024;
  localparam logic [7:0]  MAX_HDRS_RST  = 8'd32;

  typedef struct packed {
    logic [11:0] max_line_length;
    logic [7:0]  max_name_length;
    logic [11:0] max_value_length;
    logic [7:0]  max_header_count;
  } hrhp_cfg_t;

  // Result kinds.
  localparam logic [1:0] EV_LINE   = 2'd0;
  localparam logic [1:0] EV_HEADER = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;
  localparam logic [1:0] EV_REJECT = 2'd3;

  // Rejection codes.
  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_METHOD  = 4'd1;
  localparam logic [3:0] ERR_CHAR    = 4'd2;
  localparam logic [3:0] ERR_LENGTH  = 4'd3;
  localparam logic [3:0] ERR_VERSION = 4'd4;
  localparam logic [3:0] ERR_COUNT   = 4'd5;
  localparam logic [3:0] ERR_NAME    = 4'd6;
  localparam logic [3:0] ERR_VALUE   = 4'd7;
  localparam logic [3:0] ERR_TRUNC   = 4'd8;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7f;

  localparam logic [11:0] MIN_NL_OFFSET = 12'd14;
  localparam int unsigned GET_LEN  = 5;
  localparam int unsigned HEAD_LEN = 6;
  localparam int unsigned VER_LEN  = 7;
  localparam int unsigned TAIL_DEPTH = 9;

  // "HTTP/1." in stream order.
  localparam logic [7:0] VER_TEXT [VER_LEN] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e};

  // Expected method prefix byte: "HEAD /" or "GET /".
  function automatic logic [7:0] prefix_byte(input logic head, input logic [2:0] pos);
    logic [7:0] b;
    b = 8'h00;
    if (head) begin
      case (pos)
        3'd0: b = 8'h48;
        3'd1: b = 8'h45;
        3'd2: b = 8'h41;
        3'd3: b = 8'h44;
        3'd4: b = 8'h20;
        3'd5: b = 8'h2f;
        default: b = 8'h00;
      endcase
    end else begin
      case (pos)
        3'd0: b = 8'h47;
        3'd1: b = 8'h45;
        3'd2: b = 8'h54;
        3'd3: b = 8'h20;
        3'd4: b = 8'h2f;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h61 && b <= 8'h7a) || b == 8'h2d || b == 8'h5f;
  endfunction

endpackage

// ===== src/hrhp_cfg_regs.sv =====
module hrhp_cfg_regs
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hrhp_cfg_t   cfg
);

  hrhp_cfg_t cfg_r;
  hrhp_cfg_t cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MAX_LINE:  cfg_nxt.max_line_length  = pwdata[11:0];
        REG_MAX_NAME:  cfg_nxt.max_name_length  = pwdata[7:0];
        REG_MAX_VALUE: cfg_nxt.max_value_length = pwdata[11:0];
        REG_MAX_HDRS:  cfg_nxt.max_header_count = pwdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_LINE:  prdata = {20'd0, cfg_r.max_line_length};
      REG_MAX_NAME:  prdata = {24'd0, cfg_r.max_name_length};
      REG_MAX_VALUE: prdata = {20'd0, cfg_r.max_value_length};
      REG_MAX_HDRS:  prdata = {24'd0, cfg_r.max_header_count};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_line_length  <= MAX_LINE_RST;
      cfg_r.max_name_length  <= MAX_NAME_RST;
      cfg_r.max_value_length <= MAX_VALUE_RST;
      cfg_r.max_header_count <= MAX_HDRS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/http_request_header_parser.sv =====
// HTTP request header parser. Takes one request byte per cycle on the in_ channel and
// reports at most one result per byte on the out_ channel: request line accepted, header
// framed (index, name and value lengths), headers complete, or a coded rejection. Each byte
// is handled by the combinational phase logic; its result sits in the output register
// the cycle after acceptance, and a new byte is taken every cycle while that register is
// empty or being drained, so the sustained rate is one byte per clock. After completion or
// rejection, bytes are consumed silently until one arrives with in_first_of_flow set.
// Limit registers sit at byte addresses 0x0 (line), 0x4 (name), 0x8 (value) and 0xC
// (header count) and should be written while the block is idle.
`include "http_request_header_parser_defines.svh"

module http_request_header_parser
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_flow,
  input  logic        in_end_of_data,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [3:0]  out_error_code,
  output logic        out_minor_is_one,
  output logic [7:0]  out_header_index,
  output logic [7:0]  out_name_length,
  output logic [11:0] out_value_length,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LINE   = 3'd1;
  localparam logic [2:0] PH_LSTART = 3'd2;
  localparam logic [2:0] PH_NAME   = 3'd3;
  localparam logic [2:0] PH_COLON  = 3'd4;
  localparam logic [2:0] PH_VALUE  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_REJECT = 3'd7;

  hrhp_cfg_t cfg;

  hrhp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parse state.
  logic [2:0]  phase_r, phase_nxt;
  logic [11:0] line_offset_r, line_offset_nxt;
  logic [7:0]  name_count_r, name_count_nxt;
  logic [11:0] value_count_r, value_count_nxt;
  logic [7:0]  headers_seen_r, headers_seen_nxt;
  logic        method_head_r, method_head_nxt;
  logic        version_one_r, version_one_nxt;
  logic [7:0]  tail_r [TAIL_DEPTH];
  logic [7:0]  tail_nxt [TAIL_DEPTH];

  // Output register.
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [3:0]  err_r;
  logic        minor_r;
  logic [7:0]  idx_r;
  logic [7:0]  nlen_r;
  logic [11:0] vlen_r;

  logic        in_fire;

  // Working view of the state after an optional flow restart.
  logic        restart;
  logic [2:0]  cur_phase;
  logic [11:0] cur_off;
  logic [7:0]  cur_name;
  logic [11:0] cur_value;
  logic [7:0]  cur_hdrs;
  logic        cur_head;
  logic        cur_vone;
  logic [7:0]  cur_tail [TAIL_DEPTH];

  logic        head_now;
  logic        in_prefix;
  logic [7:0]  pfx;
  logic        match_cr, match_lf, ver_ok;
  logic [7:0]  minor_byte;
  logic        do_name, do_value;
  logic [7:0]  name_base;

  logic        ev_valid;
  logic [1:0]  ev_kind;
  logic [3:0]  ev_err;
  logic [7:0]  ev_idx;
  logic [7:0]  ev_nlen;
  logic [11:0] ev_vlen;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    restart   = in_first_of_flow || (phase_r == PH_IDLE);
    cur_phase = restart ? PH_LINE : phase_r;
    cur_off   = restart ? 12'd0 : line_offset_r;
    cur_name  = restart ? 8'd0 : name_count_r;
    cur_value = restart ? 12'd0 : value_count_r;
    cur_hdrs  = restart ? 8'd0 : headers_seen_r;
    cur_head  = restart ? 1'b0 : method_head_r;
    cur_vone  = restart ? 1'b0 : version_one_r;
    for (int k = 0; k < TAIL_DEPTH; k++) begin
      cur_tail[k] = restart ? 8'd0 : tail_r[k];
    end

    head_now  = (cur_off == 12'd0) ? (in_data_byte == CH_H) : cur_head;
    in_prefix = head_now ? (cur_off < 12'(HEAD_LEN)) : (cur_off < 12'(GET_LEN));
    pfx       = prefix_byte(head_now, cur_off[2:0]);

    // The version text and its minor digit end either right before the newline or one byte earlier, before a CR.
    match_cr = 1'b1;
    match_lf = 1'b1;
    for (int k = 0; k < VER_LEN; k++) begin
      match_cr = match_cr && (cur_tail[VER_LEN + 1 - k] == VER_TEXT[k]);
      match_lf = match_lf && (cur_tail[VER_LEN - k] == VER_TEXT[k]);
    end
    ver_ok     = (cur_tail[0] == CH_CR) ? match_cr : match_lf;
    minor_byte = (cur_tail[0] == CH_CR) ? cur_tail[1] : cur_tail[0];

    phase_nxt        = cur_phase;
    line_offset_nxt  = cur_off;
    name_count_nxt   = cur_name;
    value_count_nxt  = cur_value;
    headers_seen_nxt = cur_hdrs;
    method_head_nxt  = cur_head;
    version_one_nxt  = cur_vone;
    tail_nxt[0] = in_data_byte;
    for (int k = 1; k < TAIL_DEPTH; k++) begin
      tail_nxt[k] = cur_tail[k-1];
    end

    ev_valid  = 1'b0;
    ev_kind   = EV_LINE;
    ev_err    = ERR_NONE;
    ev_idx    = 8'd0;
    ev_nlen   = 8'd0;
    ev_vlen   = 12'd0;
    do_name   = 1'b0;
    do_value  = 1'b0;
    name_base = cur_name;

    unique case (cur_phase) inside
      PH_LINE: begin
        method_head_nxt = head_now;
        if (in_prefix && in_data_byte != pfx) begin
          ev_valid = 1'b1;
          ev_kind  = EV_REJECT;
          ev_err   = ERR_METHOD;
        end else if (cur_off >= cfg.max_line_length) begin
          ev_valid = 1'b1;
          ev_kind  = EV_REJECT;
          ev_err   = ERR_LENGTH;
        end else if (in_data_byte == CH_LF) begin
          ev_valid = 1'b1;
          if (cur_off < MIN_NL_OFFSET) begin
            ev_kind = EV_REJECT;
            ev_err  = ERR_LENGTH;
          end else if (!ver_ok) begin
            ev_kind = EV_REJECT;
            ev_err  = ERR_VERSION;
          end else begin
            ev_kind         = EV_LINE;
            version_one_nxt = (minor_byte == CH_ONE);
            phase_nxt       = PH_LSTART;
          end
        end else if (in_data_byte != CH_CR &&
                     (in_data_byte < PRINT_LO || in_data_byte > PRINT_HI)) begin
          ev_valid = 1'b1;
          ev_kind  = EV_REJECT;
          ev_err   = ERR_CHAR;
        end else begin
          line_offset_nxt = cur_off + 12'd1;
        end
      end
      PH_LSTART: begin
        if (in_data_byte == CH_CR || in_data_byte == CH_LF) begin
          ev_valid  = 1'b1;
          ev_kind   = EV_DONE;
          phase_nxt = PH_DONE;
        end else if (cur_hdrs >= cfg.max_header_count) begin
          ev_valid = 1'b1;
          ev_kind  = EV_REJECT;
          ev_err   = ERR_COUNT;
        end else begin
          value_count_nxt = 12'd0;
          name_base       = 8'd0;
          name_count_nxt  = 8'd0;
          phase_nxt       = PH_NAME;
          do_name         = 1'b1;
        end
      end
      PH_NAME: begin
        do_name = 1'b1;
      end
      PH_COLON: begin
        phase_nxt = PH_VALUE;
        do_value  = !(in_data_byte == CH_SPACE || in_data_byte == CH_TAB);
      end
      PH_VALUE: begin
        do_value = 1'b1;
      end
      PH_IDLE, PH_DONE, PH_REJECT: begin
        // Finished flow: the byte is dropped and the state is left alone.
        for (int k = 0; k < TAIL_DEPTH; k++) begin
          tail_nxt[k] = cur_tail[k];
        end
      end
    endcase

    if (do_name) begin
      if (is_name_char(in_data_byte)) begin
        if (name_base >= cfg.max_name_length) begin
          ev_valid = 1'b1;
          ev_kind  = EV_REJECT;
          ev_err   = ERR_NAME;
        end else begin
          name_count_nxt = name_base + 8'd1;
        end
      end else if (in_data_byte == CH_COLON && name_base != 8'd0) begin
        phase_nxt = PH_COLON;
      end else begin
        ev_valid = 1'b1;
        ev_kind  = EV_REJECT;
        ev_err   = ERR_NAME;
      end
    end

    if (do_value) begin
      if (in_data_byte == CH_LF) begin
        ev_valid = 1'b1;
        ev_kind  = EV_HEADER;
        ev_idx   = cur_hdrs;
        ev_nlen  = cur_name;
        ev_vlen  = (cur_value != 12'd0 && cur_tail[0] == CH_CR) ? cur_value - 12'd1
                                                                 : cur_value;
        if (cur_hdrs != 8'hff) begin
          headers_seen_nxt = cur_hdrs + 8'd1;
        end
        phase_nxt = PH_LSTART;
      end else if (cur_value >= cfg.max_value_length) begin
        ev_valid = 1'b1;
        ev_kind  = EV_REJECT;
        ev_err   = ERR_VALUE;
      end else begin
        value_count_nxt = cur_value + 12'd1;
      end
    end

    if (ev_valid && ev_kind == EV_REJECT) begin
      phase_nxt = PH_REJECT;
    end

    // A flow that stops mid-request is reported as truncated instead of a line or header result; a rejection wins.
    if (in_end_of_data && phase_nxt != PH_DONE && phase_nxt != PH_REJECT) begin
      ev_valid  = 1'b1;
      ev_kind   = EV_REJECT;
      ev_err    = ERR_TRUNC;
      ev_idx    = 8'd0;
      ev_nlen   = 8'd0;
      ev_vlen   = 12'd0;
      phase_nxt = PH_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        out_valid_r <= ev_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_offset_r  <= line_offset_nxt;
      name_count_r   <= name_count_nxt;
      value_count_r  <= value_count_nxt;
      headers_seen_r <= headers_seen_nxt;
      method_head_r  <= method_head_nxt;
      version_one_r  <= version_one_nxt;
      for (int k = 0; k < TAIL_DEPTH; k++) begin
        tail_r[k] <= tail_nxt[k];
      end
      kind_r  <= ev_kind;
      err_r   <= ev_err;
      minor_r <= version_one_nxt;
      idx_r   <= ev_idx;
      nlen_r  <= ev_nlen;
      vlen_r  <= ev_vlen;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_error_code   = err_r;
  assign out_minor_is_one = minor_r;
  assign out_header_index = idx_r;
  assign out_name_length  = nlen_r;
  assign out_value_length = vlen_r;

  `HRHP_ASSERT_IMPLY(a_err_only_on_reject, out_valid_r, (kind_r == EV_REJECT) == (err_r != ERR_NONE), "error code does not match result kind")
  `HRHP_ASSERT_IMPLY(a_header_fields_zero, out_valid_r && kind_r != EV_HEADER, idx_r == 8'd0 && nlen_r == 8'd0 && vlen_r == 12'd0, "header fields set on a non-header result")
  `HRHP_ASSERT_NEXT(a_done_sticky, phase_r == PH_DONE && !(in_fire && in_first_of_flow), phase_r == PH_DONE, "completed flow left its final phase without a restart")
  `HRHP_ASSERT_IMPLY(a_name_nonempty, phase_r == PH_NAME, name_count_r != 8'd0, "name phase entered with an empty name")

endmodule
